// ===== hw/rtl/cvr_pkg.sv =====
// ----------------------------------------------------------------------------
// CORDIC vector rotator package
// Shared types, constants and the arctangent table for the rotator.
// ----------------------------------------------------------------------------
package cvr_pkg;

  // Width of the internal Q7 coordinate registers.
  localparam int unsigned CoordW = 16;
  // Width of the signed residual angle register.
  localparam int unsigned AngleW = 10;
  // Width of the micro-rotation index.
  localparam int unsigned IterW  = 3;

  // Quarter turn in Q7 radians.
  localparam logic signed [AngleW-1:0] HalfPiQ7 = 10'sd201;

  // Quadrant codes left by the angle reduction.
  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;
  localparam logic [1:0] Quad3 = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StReduce = 4'b0010,
    StRotate = 4'b0100,
    StFix    = 4'b1000
  } cvr_state_e;

  // Working vector carried between the sequencer and the rotation unit.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [AngleW-1:0] a;
  } cvr_vec_t;

  // Arctangent of 2^-i in Q7 radians.
  function automatic logic signed [AngleW-1:0] atan_q7(logic [IterW-1:0] i);
    logic signed [AngleW-1:0] r;
    case (i)
      3'd0:    r = 10'sh064;
      3'd1:    r = 10'sh03B;
      3'd2:    r = 10'sh01F;
      3'd3:    r = 10'sh010;
      3'd4:    r = 10'sh008;
      3'd5:    r = 10'sh004;
      3'd6:    r = 10'sh002;
      3'd7:    r = 10'sh001;
      default: r = 10'sh000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cvr_rot_unit.sv =====
// ----------------------------------------------------------------------------
// CORDIC micro-rotation unit
// One shift-add step in rotation mode, shared by all iterations.
// ----------------------------------------------------------------------------
module cvr_rot_unit (
  input  cvr_pkg::cvr_vec_t           vec_i,
  input  logic [cvr_pkg::IterW-1:0]   iter_i,
  output cvr_pkg::cvr_vec_t           vec_o
);

  logic signed [cvr_pkg::CoordW-1:0] dx;
  logic signed [cvr_pkg::CoordW-1:0] dy;
  logic signed [cvr_pkg::AngleW-1:0] step;

  // Scaled cross terms and the table angle for this step.
  assign dx   = vec_i.x >>> iter_i;
  assign dy   = vec_i.y >>> iter_i;
  assign step = cvr_pkg::atan_q7(iter_i);

  // Rotate toward zero residual angle; the sign of the angle picks direction.
  always_comb begin
    if (!vec_i.a[cvr_pkg::AngleW-1]) begin
      vec_o.x = vec_i.x - dy;
      vec_o.y = vec_i.y + dx;
      vec_o.a = vec_i.a - step;
    end else begin
      vec_o.x = vec_i.x + dy;
      vec_o.y = vec_i.y - dx;
      vec_o.a = vec_i.a + step;
    end
  end

endmodule

// ===== hw/rtl/cordic_vector_rotator.sv =====
// An item is taken only while idle: the angle is reduced by quarter turns,
// ITERATIONS micro-rotations run on the single shared micro-rotation unit
// (one step per cycle), and the fix-up writes the output register once it is
// free or draining, and no new item is taken before that write.
// Reset clears state, iteration, quadrant and output valid; not the datapath.
// ----------------------------------------------------------------------------
// CORDIC vector rotator
// Rotates a signed 8-bit point by a Q7 angle with an iterative CORDIC core.
// ----------------------------------------------------------------------------
module cordic_vector_rotator #(
  parameter int unsigned ITERATIONS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [8:0]        angle_i,
  input  logic signed [7:0] point_x_i,
  input  logic signed [7:0] point_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] rotated_x_o,
  output logic signed [7:0] rotated_y_o
);

  localparam logic [cvr_pkg::IterW-1:0] LastIter = cvr_pkg::IterW'(ITERATIONS - 1);

  cvr_pkg::cvr_state_e               state_q, state_d;
  cvr_pkg::cvr_vec_t                 vec_q, vec_d, vec_rot;
  logic [cvr_pkg::IterW-1:0]         iter_q, iter_d;
  logic [1:0]                        quad_q, quad_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [7:0]                 res_x_q, res_x_d;
  logic signed [7:0]                 res_y_q, res_y_d;
  logic signed [7:0]                 gx, gy;

  // Gain compensation by 77/128, then drop seven fraction bits (low byte kept).
  function automatic logic signed [7:0] gain_fix(logic signed [15:0] v);
    logic signed [17:0] s;
    s = 18'(v >>> 7) + 18'(v >>> 5) + 18'(v >>> 4) + 18'(v >>> 1);
    return s[14:7];
  endfunction

  // Shared micro-rotation unit.
  cvr_rot_unit u_rot (
    .vec_i  (vec_q),
    .iter_i (iter_q),
    .vec_o  (vec_rot)
  );

  assign gx = gain_fix(vec_q.x);
  assign gy = gain_fix(vec_q.y);

  assign in_ready_o  = (state_q == cvr_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign rotated_x_o = res_x_q;
  assign rotated_y_o = res_y_q;

  // Sequencer: load, reduce, rotate, then fix up into the output register.
  always_comb begin
    state_d     = state_q;
    vec_d       = vec_q;
    iter_d      = iter_q;
    quad_d      = quad_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      cvr_pkg::StIdle: begin
        if (in_valid_i) begin
          vec_d.x = {point_x_i[7], point_x_i, 7'b0};
          vec_d.y = {point_y_i[7], point_y_i, 7'b0};
          vec_d.a = {1'b0, angle_i};
          quad_d  = cvr_pkg::Quad0;
          iter_d  = '0;
          state_d = cvr_pkg::StReduce;
        end
      end
      cvr_pkg::StReduce: begin
        if (vec_q.a >= cvr_pkg::HalfPiQ7) begin
          vec_d.a = vec_q.a - cvr_pkg::HalfPiQ7;
          quad_d  = quad_q + 2'd1;
        end else begin
          state_d = cvr_pkg::StRotate;
        end
      end
      cvr_pkg::StRotate: begin
        vec_d  = vec_rot;
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          state_d = cvr_pkg::StFix;
        end
      end
      cvr_pkg::StFix: begin
        // Wait until the output register is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          case (quad_q)
            cvr_pkg::Quad1: begin
              res_x_d = -gy;
              res_y_d = gx;
            end
            cvr_pkg::Quad2: begin
              res_x_d = -gx;
              res_y_d = -gy;
            end
            cvr_pkg::Quad3: begin
              res_x_d = gy;
              res_y_d = -gx;
            end
            default: begin
              res_x_d = gx;
              res_y_d = gy;
            end
          endcase
          out_valid_d = 1'b1;
          state_d     = cvr_pkg::StIdle;
        end
      end
      default: begin
        state_d = cvr_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvr_pkg::StIdle;
      iter_q      <= '0;
      quad_q      <= cvr_pkg::Quad0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      quad_q      <= quad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    vec_q   <= vec_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
  end

  // A 9-bit angle never needs more than two quarter turns.
  a_quad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_q != cvr_pkg::Quad3)
    else $error("quadrant count out of range");

  // Rotation starts from the first step with a reduced, nonnegative angle.
  a_rot_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == cvr_pkg::StRotate) |->
      (iter_q == '0) && !vec_q.a[cvr_pkg::AngleW-1] && (vec_q.a < cvr_pkg::HalfPiQ7))
    else $error("rotation entered with bad iteration or angle");

  // Rotation only leaves toward the fix-up step.
  a_rot_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvr_pkg::StRotate) |=>
      (state_q == cvr_pkg::StRotate) || (state_q == cvr_pkg::StFix))
    else $error("rotation left to an unexpected state");

  // A result appears only when the fix-up step completes.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == cvr_pkg::StFix))
    else $error("output valid raised outside fix-up");

endmodule

// ===== verif/tb_cordic_vector_rotator.sv =====
// ----------------------------------------------------------------------------
// Testbench for the CORDIC vector rotator
// Sends angle and point transfers with bursty input traffic and a stalling
// receiver, predicts each rotated point with a behavioral model of the
// shift-add datapath, and checks the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One rotated point as the block delivers it.
typedef struct packed {
  logic signed [7:0] x;
  logic signed [7:0] y;
} rot_point_t;

// Predicts rotated points for accepted inputs and checks delivered ones.
class rotation_scoreboard;
  localparam int RotSteps = 8;

  rot_point_t  expected_q[$];
  int unsigned error_count = 0;

  // Sign-extend the low 16 bits, as the coordinate registers wrap.
  function int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  // Scale by 77/128 with shifts and adds, then drop seven fraction bits.
  function int gain_fix(int v);
    int s;
    s = (v >>> 7) + (v >>> 5) + (v >>> 4) + (v >>> 1);
    return wrap16(s >>> 7);
  endfunction

  // Full rotation: quadrant reduction, micro-rotations, gain, quadrant fix-up.
  function rot_point_t rotate_point(logic [8:0] ang, logic signed [7:0] px,
                                    logic signed [7:0] py);
    int         resid;
    int         x;
    int         y;
    int         dx;
    int         dy;
    int         tx;
    int         ty;
    int         atan_tab[RotSteps];
    logic [1:0] quad;
    rot_point_t res;
    atan_tab = '{'h64, 'h3B, 'h1F, 'h10, 'h08, 'h04, 'h02, 'h01};
    resid = int'(ang);
    x = wrap16(int'(px) * 128);
    y = wrap16(int'(py) * 128);
    quad = cvr_pkg::Quad0;
    while (resid >= int'(cvr_pkg::HalfPiQ7)) begin
      resid -= int'(cvr_pkg::HalfPiQ7);
      quad = quad + 2'd1;
    end
    // Each step turns toward the residual angle.
    for (int i = 0; i < RotSteps; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (resid >= 0) begin
        x = wrap16(x - dy);
        y = wrap16(y + dx);
        resid -= atan_tab[i];
      end else begin
        x = wrap16(x + dy);
        y = wrap16(y - dx);
        resid += atan_tab[i];
      end
    end
    x = gain_fix(x);
    y = gain_fix(y);
    case (quad)
      cvr_pkg::Quad1: begin
        tx = wrap16(-y);
        ty = x;
      end
      cvr_pkg::Quad2: begin
        tx = wrap16(-x);
        ty = wrap16(-y);
      end
      cvr_pkg::Quad3: begin
        tx = y;
        ty = wrap16(-x);
      end
      default: begin
        tx = x;
        ty = y;
      end
    endcase
    res.x = tx[7:0];
    res.y = ty[7:0];
    return res;
  endfunction

  function void note_input(logic [8:0] ang, logic signed [7:0] px,
                           logic signed [7:0] py);
    expected_q.push_back(rotate_point(ang, px, py));
  endfunction

  // Every mismatch is printed and counted.
  function void report(string what, int exp_v, int act_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  function void check_result(logic signed [7:0] rx, logic signed [7:0] ry);
    rot_point_t exp_pt;
    if (expected_q.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result x=%0d y=%0d", $time, rx, ry);
      return;
    end
    exp_pt = expected_q.pop_front();
    if (rx !== exp_pt.x) report("rotated_x", exp_pt.x, rx);
    if (ry !== exp_pt.y) report("rotated_y", exp_pt.y, ry);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_cordic_vector_rotator;

  localparam int RandomItems   = 1200;
  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 30;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [8:0]        angle_i;
  logic signed [7:0] point_x_i;
  logic signed [7:0] point_y_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic signed [7:0] rotated_x_o;
  logic signed [7:0] rotated_y_o;

  rotation_scoreboard rot_sb = new();
  bit                 hold_off_req = 1'b0;
  int                 idle_cycles  = 0;

  cordic_vector_rotator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .angle_i    (angle_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rotated_x_o(rotated_x_o),
    .rotated_y_o(rotated_y_o)
  );

  always #2 clk_i = ~clk_i;

  // Offer one item from a falling edge and hold it until the transfer.
  task automatic send_point(input logic [8:0] ang, input logic signed [7:0] px,
                            input logic signed [7:0] py);
    in_valid_i <= 1'b1;
    angle_i    <= ang;
    point_x_i  <= px;
    point_y_i  <= py;
    do @(posedge clk_i); while (!in_ready_o);
    rot_sb.note_input(ang, px, py);
    @(negedge clk_i);
  endtask

  // Coordinates lean toward the extremes now and then.
  function automatic logic signed [7:0] pick_coord();
    logic signed [7:0] corners[4];
    corners = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Angles lean toward the quarter-turn boundaries now and then.
  function automatic logic [8:0] pick_angle();
    logic [8:0] edges[7];
    edges = '{9'd0, 9'd200, 9'd201, 9'd401, 9'd402, 9'd403, 9'd511};
    if ($urandom_range(0, 6) == 0) return edges[$urandom_range(0, 6)];
    return 9'($urandom_range(0, 511));
  endfunction

  // Main stimulus: reset, directed corners, then bursty random traffic.
  initial begin
    int          dir_angles[12];
    logic signed [7:0] dir_x[6];
    logic signed [7:0] dir_y[6];
    int          sent;
    int          burst;
    int          gap;
    dir_angles = '{0, 1, 100, 200, 201, 202, 300, 401, 402, 403, 450, 511};
    dir_x      = '{8'sd127, -8'sd128, -8'sd128, 8'sd127, 8'sd0, 8'sd1};
    dir_y      = '{8'sd127, -8'sd128, 8'sd127, -8'sd128, 8'sd0, -8'sd1};
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    angle_i    = '0;
    point_x_i  = '0;
    point_y_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Each reachable quadrant and boundary angle, with the corner points.
    for (int i = 0; i < 12; i++) begin
      send_point(9'(dir_angles[i]), dir_x[i % 6], dir_y[i % 6]);
    end
    for (int i = 0; i < 6; i++) begin
      send_point(9'd511, dir_x[i], dir_y[i]);
    end

    // Random traffic; the receiver starts with a long hold-off.
    hold_off_req = 1'b1;
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RandomItems; k++) begin
        send_point(pick_angle(), pick_coord(), pick_coord());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then allow for stray ones.
    while (rot_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (rot_sb.error_count == 0 && rot_sb.pending() == 0) begin
      $display("tb_cordic_vector_rotator: done, clean");
    end else begin
      $display("tb_cordic_vector_rotator: done, errors");
    end
    $finish;
  end

  // Receiver: a changing stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    int period;
    int phase;
    out_ready_i = 1'b0;
    mode_left   = 0;
    mode        = 0;
    period      = 1;
    phase       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          period    = $urandom_range(2, 8);
          phase     = 0;
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (phase % period) == 0;
          default: out_ready_i <= $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      rot_sb.check_result(rotated_x_o, rotated_y_o);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_cordic_vector_rotator: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
